@@ src/amtrs_pkg.sv @@
// amtrs_pkg: shared types, constants and arithmetic step functions
// for the affine transform decomposition unit; no dependencies
package amtrs_pkg;

   localparam int NUM_AXIS   = 3;
   localparam int NUM_ELEM   = 9;
   localparam int NUM_QUAT   = 4;
   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS  = 31;

   // one in signed q2.30
   localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

   // input item: nine basis elements (column * 3 + component) and translation
   typedef struct packed {
      logic [NUM_ELEM-1:0][31:0] col;
      logic [NUM_AXIS-1:0][31:0] move;
   } xform_type;

   // queue entry: rotation matrix in q2.30 plus the pass-through fields
   typedef struct packed {
      logic [NUM_AXIS-1:0][31:0] trans;
      logic [NUM_AXIS-1:0][31:0] scale;
      logic [NUM_ELEM-1:0][31:0] rot;
   } entry_type;

   // result item, quaternion order w x y z
   typedef struct packed {
      logic [NUM_AXIS-1:0][31:0] trans;
      logic [NUM_AXIS-1:0][31:0] scale;
      logic [NUM_QUAT-1:0][31:0] quat;
   } result_type;

   // quaternion extraction case
   typedef enum logic [1:0] {
      CASE_TRACE,
      CASE_X,
      CASE_Y,
      CASE_Z
   } case_type;

   // one digit of a restoring square root
   typedef struct packed {
      logic [63:0] src;
      logic [34:0] rem;
      logic [31:0] root;
   } sqrt_type;

   // one bit of a restoring division producing a 31-bit quotient
   typedef struct packed {
      logic [31:0] rem;
      logic [30:0] low;
      logic [30:0] quo;
   } div_type;

   function automatic sqrt_type sqrt_init(logic [63:0] value);
      sqrt_type s;
      s.src  = value;
      s.rem  = '0;
      s.root = '0;
      return s;
   endfunction

   function automatic sqrt_type sqrt_step(sqrt_type s);
      sqrt_type    o;
      logic [34:0] rem_sh;
      logic [34:0] trial;
      rem_sh = {s.rem[32:0], s.src[63:62]};
      trial  = {1'b0, s.root, 2'b01};
      o.src  = {s.src[61:0], 2'b00};
      if (rem_sh >= trial) begin
         o.rem  = rem_sh - trial;
         o.root = {s.root[30:0], 1'b1};
      end else begin
         o.rem  = rem_sh;
         o.root = {s.root[30:0], 1'b0};
      end
      return o;
   endfunction

   // dividend is mag * 2^30; top bits start below the divisor
   function automatic div_type div_init(logic [31:0] mag);
      div_type s;
      s.rem = {1'b0, mag[31:1]};
      s.low = {mag[0], 30'd0};
      s.quo = '0;
      return s;
   endfunction

   function automatic div_type div_step(div_type s, logic [31:0] dvsr);
      div_type     o;
      logic [32:0] rs;
      rs    = {s.rem, s.low[30]};
      o.low = {s.low[29:0], 1'b0};
      if (rs >= {1'b0, dvsr}) begin
         o.rem = 32'(rs - {1'b0, dvsr});
         o.quo = {s.quo[29:0], 1'b1};
      end else begin
         o.rem = rs[31:0];
         o.quo = {s.quo[29:0], 1'b0};
      end
      return o;
   endfunction

endpackage

@@ src/amtrs_front.sv @@
// amtrs_front: column lengths and normalized rotation matrix, fully pipelined
// depends on amtrs_pkg
module amtrs_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  amtrs_pkg::xform_type  req_item,
   output logic                  out_push,
   output amtrs_pkg::entry_type  out_item,
   input  logic                  out_full
);

   localparam int DEPTH = 3 + amtrs_pkg::SQRT_STEPS + amtrs_pkg::DIV_STEPS;

   typedef struct packed {
      logic [amtrs_pkg::NUM_ELEM-1:0]       neg;
      logic [amtrs_pkg::NUM_ELEM-1:0][31:0] mag;
      logic [amtrs_pkg::NUM_AXIS-1:0][31:0] trans;
   } carry_type;

   logic [DEPTH-1:0]    vld_ff, vld_in;
   logic                advance;
   carry_type           car_in;
   carry_type           car_ff [DEPTH];
   logic [63:0]         sq_ff [amtrs_pkg::NUM_ELEM];
   logic [63:0]         acc_ff [amtrs_pkg::NUM_AXIS];
   amtrs_pkg::sqrt_type sqs_ff [amtrs_pkg::SQRT_STEPS][amtrs_pkg::NUM_AXIS];
   logic [31:0]         scl_ff [amtrs_pkg::DIV_STEPS][amtrs_pkg::NUM_AXIS];
   amtrs_pkg::div_type  dvs_ff [amtrs_pkg::DIV_STEPS][amtrs_pkg::NUM_ELEM];
   logic [31:0]         scale_last [amtrs_pkg::NUM_AXIS];

   // whole pipe moves unless the last item cannot enter the queue
   assign advance   = !(vld_ff[DEPTH-1] && out_full);
   assign req_stall = !advance;
   assign out_push  = vld_ff[DEPTH-1] && advance;

   always_comb begin
      vld_in = advance ? {vld_ff[DEPTH-2:0], req_valid} : vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // sign and magnitude of each element
   always_comb begin
      car_in.trans = req_item.move;
      for (int e = 0; e < amtrs_pkg::NUM_ELEM; e++) begin
         car_in.neg[e] = req_item.col[e][31];
         car_in.mag[e] = req_item.col[e][31] ? (~req_item.col[e] + 32'd1) : req_item.col[e];
      end
   end

   // length clamped to one lsb
   always_comb begin
      for (int a = 0; a < amtrs_pkg::NUM_AXIS; a++) begin
         scale_last[a] = (sqs_ff[amtrs_pkg::SQRT_STEPS-1][a].root == 32'd0) ? 32'd1
                         : sqs_ff[amtrs_pkg::SQRT_STEPS-1][a].root;
      end
   end

   // squares, sums, root digits, then quotient bits
   always_ff @(posedge clock) begin
      if (advance) begin
         car_ff[0] <= car_in;
         for (int k = 1; k < DEPTH; k++) begin
            car_ff[k] <= car_ff[k-1];
         end
         for (int e = 0; e < amtrs_pkg::NUM_ELEM; e++) begin
            sq_ff[e] <= {32'd0, car_ff[0].mag[e]} * {32'd0, car_ff[0].mag[e]};
         end
         for (int a = 0; a < amtrs_pkg::NUM_AXIS; a++) begin
            acc_ff[a] <= sq_ff[a*3] + sq_ff[a*3+1] + sq_ff[a*3+2];
            sqs_ff[0][a] <= amtrs_pkg::sqrt_step(amtrs_pkg::sqrt_init(acc_ff[a]));
            for (int k = 1; k < amtrs_pkg::SQRT_STEPS; k++) begin
               sqs_ff[k][a] <= amtrs_pkg::sqrt_step(sqs_ff[k-1][a]);
            end
            scl_ff[0][a] <= scale_last[a];
            for (int k = 1; k < amtrs_pkg::DIV_STEPS; k++) begin
               scl_ff[k][a] <= scl_ff[k-1][a];
            end
            for (int j = 0; j < amtrs_pkg::NUM_AXIS; j++) begin
               dvs_ff[0][a*3+j] <= amtrs_pkg::div_step(
                  amtrs_pkg::div_init(car_ff[amtrs_pkg::SQRT_STEPS+2].mag[a*3+j]),
                  scale_last[a]);
               for (int k = 1; k < amtrs_pkg::DIV_STEPS; k++) begin
                  dvs_ff[k][a*3+j] <= amtrs_pkg::div_step(dvs_ff[k-1][a*3+j], scl_ff[k-1][a]);
               end
            end
         end
      end
   end

   // signed rotation elements toward the queue
   always_comb begin
      out_item.trans = car_ff[DEPTH-1].trans;
      for (int a = 0; a < amtrs_pkg::NUM_AXIS; a++) begin
         out_item.scale[a] = scl_ff[amtrs_pkg::DIV_STEPS-1][a];
      end
      for (int e = 0; e < amtrs_pkg::NUM_ELEM; e++) begin
         out_item.rot[e] = car_ff[DEPTH-1].neg[e]
            ? (~{1'b0, dvs_ff[amtrs_pkg::DIV_STEPS-1][e].quo} + 32'd1)
            : {1'b0, dvs_ff[amtrs_pkg::DIV_STEPS-1][e].quo};
      end
   end

endmodule

@@ src/amtrs_queue.sv @@
// amtrs_queue: short register queue between the front and back pipelines
// depends on amtrs_pkg
module amtrs_queue #(
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  amtrs_pkg::entry_type push_item,
   output logic                 full,
   input  logic                 pop,
   output amtrs_pkg::entry_type head,
   output logic                 nonempty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   amtrs_pkg::entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;

   assign full     = (cnt_ff == CNT_W'(DEPTH));
   assign nonempty = (cnt_ff != '0);
   assign head     = mem_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ src/amtrs_back.sv @@
// amtrs_back: rotation matrix to normalized quaternion, fully pipelined,
// with the result register; depends on amtrs_pkg
module amtrs_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_nonempty,
   output logic                  in_pop,
   input  amtrs_pkg::entry_type  in_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output amtrs_pkg::result_type rsp_item
);

   localparam int DEPTH = 8 + amtrs_pkg::SQRT_STEPS + amtrs_pkg::DIV_STEPS;

   typedef struct packed {
      logic [amtrs_pkg::NUM_AXIS-1:0][31:0] trans;
      logic [amtrs_pkg::NUM_AXIS-1:0][31:0] scale;
      logic [amtrs_pkg::NUM_QUAT-1:0]       neg;
      logic                                 degen;
      logic [amtrs_pkg::NUM_QUAT-1:0][30:0] mg;
   } carry_type;

   logic [DEPTH-1:0]      vld_ff, vld_in;
   logic                  advance;
   logic                  rsp_vld_ff;
   amtrs_pkg::result_type rsp_ff, rsp_in;
   carry_type             car_ff [DEPTH];
   carry_type             car0_in, car2_in, car5_in;
   logic [31:0]           r0_ff [amtrs_pkg::NUM_ELEM];
   logic [31:0]           r1_ff [amtrs_pkg::NUM_ELEM];
   amtrs_pkg::case_type   cs1_ff, cs1_in;
   logic signed [34:0]    rs0 [amtrs_pkg::NUM_ELEM];
   logic signed [34:0]    rs1 [amtrs_pkg::NUM_ELEM];
   logic signed [34:0]    tr0;
   logic signed [34:0]    dd;
   logic signed [34:0]    v_in [amtrs_pkg::NUM_QUAT];
   logic signed [34:0]    v2_ff [amtrs_pkg::NUM_QUAT];
   logic [34:0]           mg_in [amtrs_pkg::NUM_QUAT];
   logic [34:0]           top_in;
   logic [34:0]           mg3_ff [amtrs_pkg::NUM_QUAT];
   logic [34:0]           top3_ff;
   logic [34:0]           mg4_ff [amtrs_pkg::NUM_QUAT];
   logic [5:0]            p_in, p4_ff;
   logic [34:0]           sh [amtrs_pkg::NUM_QUAT];
   logic [61:0]           sq6_ff [amtrs_pkg::NUM_QUAT];
   logic [63:0]           sum7_ff;
   amtrs_pkg::sqrt_type   sqs_ff [amtrs_pkg::SQRT_STEPS];
   logic [31:0]           norm_last;
   logic [31:0]           nrm_ff [amtrs_pkg::DIV_STEPS];
   amtrs_pkg::div_type    dvs_ff [amtrs_pkg::DIV_STEPS][amtrs_pkg::NUM_QUAT];

   // pipe moves unless the result register is held
   assign advance   = !(rsp_vld_ff && rsp_stall);
   assign in_pop    = in_nonempty && advance;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_item  = rsp_ff;

   always_comb begin
      vld_in = advance ? {vld_ff[DEPTH-2:0], in_pop} : vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
         if (advance) begin
            rsp_vld_ff <= vld_ff[DEPTH-1];
         end
      end
   end

   // entry fields into the carry
   always_comb begin
      car0_in       = '0;
      car0_in.trans = in_item.trans;
      car0_in.scale = in_item.scale;
   end

   // trace and case choice, strict compares
   always_comb begin
      for (int e = 0; e < amtrs_pkg::NUM_ELEM; e++) begin
         rs0[e] = signed'({{3{r0_ff[e][31]}}, r0_ff[e]});
         rs1[e] = signed'({{3{r1_ff[e][31]}}, r1_ff[e]});
      end
      tr0 = rs0[0] + rs0[4] + rs0[8];
      if (tr0 > 35'sd0) begin
         cs1_in = amtrs_pkg::CASE_TRACE;
      end else if (rs0[0] > rs0[4] && rs0[0] > rs0[8]) begin
         cs1_in = amtrs_pkg::CASE_X;
      end else if (rs0[4] > rs0[8]) begin
         cs1_in = amtrs_pkg::CASE_Y;
      end else begin
         cs1_in = amtrs_pkg::CASE_Z;
      end
   end

   // unnormalized quaternion terms
   always_comb begin
      unique case (cs1_ff)
         amtrs_pkg::CASE_TRACE: begin
            dd      = signed'({3'd0, amtrs_pkg::ONE_Q30}) + rs1[0] + rs1[4] + rs1[8];
            v_in[0] = dd;
            v_in[1] = rs1[5] - rs1[7];
            v_in[2] = rs1[6] - rs1[2];
            v_in[3] = rs1[1] - rs1[3];
         end
         amtrs_pkg::CASE_X: begin
            dd      = signed'({3'd0, amtrs_pkg::ONE_Q30}) + rs1[0] - rs1[4] - rs1[8];
            v_in[0] = rs1[5] - rs1[7];
            v_in[1] = dd;
            v_in[2] = rs1[3] + rs1[1];
            v_in[3] = rs1[6] + rs1[2];
         end
         amtrs_pkg::CASE_Y: begin
            dd      = signed'({3'd0, amtrs_pkg::ONE_Q30}) + rs1[4] - rs1[0] - rs1[8];
            v_in[0] = rs1[6] - rs1[2];
            v_in[1] = rs1[3] + rs1[1];
            v_in[2] = dd;
            v_in[3] = rs1[7] + rs1[5];
         end
         default: begin
            dd      = signed'({3'd0, amtrs_pkg::ONE_Q30}) + rs1[8] - rs1[0] - rs1[4];
            v_in[0] = rs1[1] - rs1[3];
            v_in[1] = rs1[6] + rs1[2];
            v_in[2] = rs1[7] + rs1[5];
            v_in[3] = dd;
         end
      endcase
      car2_in       = car_ff[1];
      car2_in.degen = (dd <= 35'sd0);
      for (int q = 0; q < amtrs_pkg::NUM_QUAT; q++) begin
         car2_in.neg[q] = v_in[q][34];
      end
   end

   // magnitudes and their maximum
   always_comb begin
      top_in = '0;
      for (int q = 0; q < amtrs_pkg::NUM_QUAT; q++) begin
         mg_in[q] = v2_ff[q][34] ? 35'(-v2_ff[q]) : v2_ff[q];
         if (mg_in[q] > top_in) begin
            top_in = mg_in[q];
         end
      end
   end

   // leading one of the maximum
   always_comb begin
      p_in = '0;
      for (int b = 0; b < 35; b++) begin
         if (top3_ff[b]) begin
            p_in = 6'(b);
         end
      end
   end

   // shift so the maximum lands in [2^30, 2^31)
   always_comb begin
      car5_in = car_ff[4];
      for (int q = 0; q < amtrs_pkg::NUM_QUAT; q++) begin
         if (p4_ff > 6'd30) begin
            sh[q] = mg4_ff[q] >> (p4_ff - 6'd30);
         end else begin
            sh[q] = mg4_ff[q] << (6'd30 - p4_ff);
         end
         car5_in.mg[q] = sh[q][30:0];
      end
   end

   assign norm_last = (sqs_ff[amtrs_pkg::SQRT_STEPS-1].root == 32'd0) ? 32'd1
                      : sqs_ff[amtrs_pkg::SQRT_STEPS-1].root;

   // stage registers
   always_ff @(posedge clock) begin
      if (advance) begin
         car_ff[0] <= car0_in;
         for (int k = 1; k < DEPTH; k++) begin
            if (k == 2) begin
               car_ff[k] <= car2_in;
            end else if (k == 5) begin
               car_ff[k] <= car5_in;
            end else begin
               car_ff[k] <= car_ff[k-1];
            end
         end
         for (int e = 0; e < amtrs_pkg::NUM_ELEM; e++) begin
            r0_ff[e] <= in_item.rot[e];
            r1_ff[e] <= r0_ff[e];
         end
         cs1_ff  <= cs1_in;
         top3_ff <= top_in;
         p4_ff   <= p_in;
         for (int q = 0; q < amtrs_pkg::NUM_QUAT; q++) begin
            v2_ff[q]  <= v_in[q];
            mg3_ff[q] <= mg_in[q];
            mg4_ff[q] <= mg3_ff[q];
            sq6_ff[q] <= {31'd0, car_ff[5].mg[q]} * {31'd0, car_ff[5].mg[q]};
         end
         sum7_ff <= {2'd0, sq6_ff[0]} + {2'd0, sq6_ff[1]} + {2'd0, sq6_ff[2]}
                    + {2'd0, sq6_ff[3]};
         sqs_ff[0] <= amtrs_pkg::sqrt_step(amtrs_pkg::sqrt_init(sum7_ff));
         for (int k = 1; k < amtrs_pkg::SQRT_STEPS; k++) begin
            sqs_ff[k] <= amtrs_pkg::sqrt_step(sqs_ff[k-1]);
         end
         nrm_ff[0] <= norm_last;
         for (int k = 1; k < amtrs_pkg::DIV_STEPS; k++) begin
            nrm_ff[k] <= nrm_ff[k-1];
         end
         for (int q = 0; q < amtrs_pkg::NUM_QUAT; q++) begin
            dvs_ff[0][q] <= amtrs_pkg::div_step(
               amtrs_pkg::div_init({1'b0, car_ff[amtrs_pkg::SQRT_STEPS+7].mg[q]}), norm_last);
            for (int k = 1; k < amtrs_pkg::DIV_STEPS; k++) begin
               dvs_ff[k][q] <= amtrs_pkg::div_step(dvs_ff[k-1][q], nrm_ff[k-1]);
            end
         end
         rsp_ff <= rsp_in;
      end
   end

   // signs back on, identity for a degenerate rotation
   always_comb begin
      rsp_in.trans = car_ff[DEPTH-1].trans;
      rsp_in.scale = car_ff[DEPTH-1].scale;
      for (int q = 0; q < amtrs_pkg::NUM_QUAT; q++) begin
         rsp_in.quat[q] = car_ff[DEPTH-1].neg[q]
            ? (~{1'b0, dvs_ff[amtrs_pkg::DIV_STEPS-1][q].quo} + 32'd1)
            : {1'b0, dvs_ff[amtrs_pkg::DIV_STEPS-1][q].quo};
      end
      if (car_ff[DEPTH-1].degen) begin
         rsp_in.quat[0] = amtrs_pkg::ONE_Q30;
         rsp_in.quat[1] = '0;
         rsp_in.quat[2] = '0;
         rsp_in.quat[3] = '0;
      end
   end

endmodule

@@ src/affine_matrix_to_trs_decompose_unit.sv @@
// affine_matrix_to_trs_decompose_unit: top level, affine transform to
// translation, scale and unit quaternion; depends on amtrs_pkg, amtrs_front,
// amtrs_queue, amtrs_back
//
//   port group  direction  handshake            payload
//   req_        in         req_valid/req_stall  three basis columns, translation (q16.16)
//   rsp_        out        rsp_valid/rsp_stall  translation, scale (q16.16), quaternion (q2.30)
//
// one item per cycle sustained while rsp_stall stays low; an item passes through
// 66 front stages (32 root digits, 31 quotient bits), the queue, 71 back
// stages and the result register.
// reset clears only valid bits, queue pointers and the queue count.
// a held result stalls the back pipe; the front keeps going until the queue
// (QUEUE_DEPTH entries) fills, and only then raises req_stall.
module affine_matrix_to_trs_decompose_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_col0_x,
   input  logic signed [31:0] req_col0_y,
   input  logic signed [31:0] req_col0_z,
   input  logic signed [31:0] req_col1_x,
   input  logic signed [31:0] req_col1_y,
   input  logic signed [31:0] req_col1_z,
   input  logic signed [31:0] req_col2_x,
   input  logic signed [31:0] req_col2_y,
   input  logic signed [31:0] req_col2_z,
   input  logic signed [31:0] req_move_x,
   input  logic signed [31:0] req_move_y,
   input  logic signed [31:0] req_move_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_trans_x,
   output logic signed [31:0] rsp_trans_y,
   output logic signed [31:0] rsp_trans_z,
   output logic        [31:0] rsp_scale_x,
   output logic        [31:0] rsp_scale_y,
   output logic        [31:0] rsp_scale_z,
   output logic signed [31:0] rsp_quat_w,
   output logic signed [31:0] rsp_quat_x,
   output logic signed [31:0] rsp_quat_y,
   output logic signed [31:0] rsp_quat_z
);

   amtrs_pkg::xform_type  req_item;
   amtrs_pkg::entry_type  q_push_item, q_head;
   amtrs_pkg::result_type rsp_item;
   logic                  q_push, q_full, q_pop, q_nonempty;

   // pack the input item
   always_comb begin
      req_item.col[0]  = req_col0_x;
      req_item.col[1]  = req_col0_y;
      req_item.col[2]  = req_col0_z;
      req_item.col[3]  = req_col1_x;
      req_item.col[4]  = req_col1_y;
      req_item.col[5]  = req_col1_z;
      req_item.col[6]  = req_col2_x;
      req_item.col[7]  = req_col2_y;
      req_item.col[8]  = req_col2_z;
      req_item.move[0] = req_move_x;
      req_item.move[1] = req_move_y;
      req_item.move[2] = req_move_z;
   end

   amtrs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .out_push  (q_push),
      .out_item  (q_push_item),
      .out_full  (q_full)
   );

   amtrs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .nonempty  (q_nonempty)
   );

   amtrs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .in_nonempty (q_nonempty),
      .in_pop      (q_pop),
      .in_item     (q_head),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item)
   );

   // unpack the result item
   assign rsp_trans_x = rsp_item.trans[0];
   assign rsp_trans_y = rsp_item.trans[1];
   assign rsp_trans_z = rsp_item.trans[2];
   assign rsp_scale_x = rsp_item.scale[0];
   assign rsp_scale_y = rsp_item.scale[1];
   assign rsp_scale_z = rsp_item.scale[2];
   assign rsp_quat_w  = rsp_item.quat[0];
   assign rsp_quat_x  = rsp_item.quat[1];
   assign rsp_quat_y  = rsp_item.quat[2];
   assign rsp_quat_z  = rsp_item.quat[3];

   // queue never written when full
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("queue push while full");

   // queue never read when empty
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_nonempty)
      else $error("queue pop while empty");

   // every delivered scale is clamped to at least one lsb
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_scale_x != 32'd0 && rsp_scale_y != 32'd0 && rsp_scale_z != 32'd0))
      else $error("zero scale delivered");

endmodule
